@@ rtl/core/bmde_pkg.sv @@
// Shared types, constants and lookup functions for the battery meter display encoder.
`timescale 1ns / 1ps

package bmde_pkg;

  // Offset of the empty-battery point in millivolts.
  localparam int unsigned VOLT_OFFSET_MV = 3000;
  localparam int unsigned PCT_FULL       = 100;

  // Reciprocal constants for division by ten: (x * RECIP) >> SHIFT.
  localparam int unsigned RECIP10_MV     = 52429;  // shift 19, x below 2**15
  localparam int unsigned RECIP10_MID    = 6554;   // shift 16, x below 2**12
  localparam int unsigned RECIP10_SMALL  = 205;    // shift 11, x below 2**9

  // Mode marks in bits 23:21 of the display word.
  localparam logic [2:0] MARK_VOLTS = 3'b011;
  localparam logic [2:0] MARK_PCT   = 3'b100;

  // Level bar patterns.
  localparam logic [4:0] BAR_NONE  = 5'b00000;
  localparam logic [4:0] BAR_ONE   = 5'b10000;
  localparam logic [4:0] BAR_TWO   = 5'b11000;
  localparam logic [4:0] BAR_THREE = 5'b11100;
  localparam logic [4:0] BAR_FOUR  = 5'b11110;
  localparam logic [4:0] BAR_FULL  = 5'b11111;

  localparam logic [6:0] SEG_BLANK = 7'b0000000;

  // Everything the final stage needs to build one display word.
  typedef struct packed {
    logic       rejected;
    logic       pct_mode;
    logic       round_up;
    logic [3:0] left;
    logic [3:0] middle;
    logic [3:0] right;
    logic       pct_full;
    logic [3:0] pct_tens;
    logic [3:0] pct_ones;
    logic [4:0] bar;
  } digits_t;

  function automatic logic [6:0] seg_code(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h03;
      4'd2:    seg = 7'h6D;
      4'd3:    seg = 7'h67;
      4'd4:    seg = 7'h53;
      4'd5:    seg = 7'h76;
      4'd6:    seg = 7'h7E;
      4'd7:    seg = 7'h23;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h77;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  function automatic logic [4:0] level_bar(input logic [6:0] pct);
    logic [4:0] bar;
    if (pct >= 7'd90) begin
      bar = BAR_FULL;
    end else if (pct >= 7'd70) begin
      bar = BAR_FOUR;
    end else if (pct >= 7'd50) begin
      bar = BAR_THREE;
    end else if (pct >= 7'd30) begin
      bar = BAR_TWO;
    end else if (pct >= 7'd5) begin
      bar = BAR_ONE;
    end else begin
      bar = BAR_NONE;
    end
    return bar;
  endfunction

endpackage

@@ rtl/core/bmde_word_enc.sv @@
// Final stage logic: volts rounding, digit blanking and display word assembly.
`timescale 1ns / 1ps

module bmde_word_enc (
  input  bmde_pkg::digits_t dig,
  output logic [28:0]       display_word,
  output logic              rejected
);

  logic [3:0] l_dig;
  logic [3:0] m_dig;
  logic [3:0] r_dig;
  logic [6:0] l_seg;
  logic [6:0] m_seg;
  logic [6:0] r_seg;
  logic [2:0] mark;

  always_comb begin
    l_dig = dig.left;
    m_dig = dig.middle;
    r_dig = dig.right;
    // Round with carry; all nines stay as they are.
    if (dig.round_up) begin
      if (dig.right != 4'd9) begin
        r_dig = dig.right + 4'd1;
      end else if (dig.middle != 4'd9) begin
        r_dig = 4'd0;
        m_dig = dig.middle + 4'd1;
      end else if (dig.left != 4'd9) begin
        r_dig = 4'd0;
        m_dig = 4'd0;
        l_dig = dig.left + 4'd1;
      end
    end

    if (!dig.pct_mode) begin
      mark  = bmde_pkg::MARK_VOLTS;
      l_seg = bmde_pkg::seg_code(l_dig);
      m_seg = bmde_pkg::seg_code(m_dig);
      r_seg = bmde_pkg::seg_code(r_dig);
    end else begin
      mark  = bmde_pkg::MARK_PCT;
      r_seg = bmde_pkg::seg_code(dig.pct_ones);
      if (dig.pct_full) begin
        // One hundred reads 1, 0, 0; the tens quotient is ten here.
        l_seg = bmde_pkg::seg_code(4'd1);
        m_seg = bmde_pkg::seg_code(4'd0);
      end else if (dig.pct_tens == 4'd0) begin
        l_seg = bmde_pkg::SEG_BLANK;
        m_seg = bmde_pkg::SEG_BLANK;
      end else begin
        l_seg = bmde_pkg::SEG_BLANK;
        m_seg = bmde_pkg::seg_code(dig.pct_tens);
      end
    end

    if (dig.rejected) begin
      display_word = '0;
      rejected     = 1'b1;
    end else begin
      display_word = {dig.bar, mark, l_seg, m_seg, r_seg};
      rejected     = 1'b0;
    end
  end

endmodule

@@ rtl/core/battery_meter_display_encoder.sv @@
// Top level of the battery meter display encoder: a four-stage pipeline.
`timescale 1ns / 1ps

//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------------
//  request   | start / busy     | in_voltage_mv[15:0], in_status_byte[7:0]
//  result    | done (strobe)    | out_display_word[28:0], out_rejected
//
// One request enters in every cycle; done rises once the request has passed the
// stage one to three registers and the output register. The rate is set by the
// pipeline itself: stage one divides the sample by ten, stages two and three
// peel off decimal digits, stage four rounds and encodes. busy is always low
// because the receiver cannot stall and every stage advances each cycle.
// Reset clears only the valid bits, so no result appears until a request has
// entered.

module battery_meter_display_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_voltage_mv,
  input  logic [7:0]  in_status_byte,
  output logic        done,
  output logic [28:0] out_display_word,
  output logic        out_rejected
);

  // ---------------------------------------------------------------------
  // Stage 1: sign check, percent, and the sample divided by ten.
  // ---------------------------------------------------------------------
  logic [14:0] mv;
  logic [14:0] mv_off;
  logic [11:0] pct_raw;
  logic [6:0]  pct_nxt;
  logic [30:0] q_prod;

  logic        s1_vld_r;
  logic        s1_neg_r;
  logic        s1_mode_r;
  logic [14:0] s1_mv_r;
  logic [11:0] s1_q_r;
  logic [6:0]  s1_pct_r;

  always_comb begin
    mv      = in_voltage_mv[14:0];
    mv_off  = mv - 15'(bmde_pkg::VOLT_OFFSET_MV);
    pct_raw = mv_off[14:3];
    // Samples at or under the offset clamp to zero, large ones to full.
    if (mv <= 15'(bmde_pkg::VOLT_OFFSET_MV)) begin
      pct_nxt = 7'd0;
    end else if (pct_raw > 12'(bmde_pkg::PCT_FULL)) begin
      pct_nxt = 7'(bmde_pkg::PCT_FULL);
    end else begin
      pct_nxt = pct_raw[6:0];
    end
    q_prod = {16'd0, mv} * 31'(bmde_pkg::RECIP10_MV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_neg_r  <= in_voltage_mv[15];
    s1_mode_r <= in_status_byte[0];
    s1_mv_r   <= mv;
    s1_q_r    <= q_prod[30:19];
    s1_pct_r  <= pct_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 2: rounding remainder, right digit, percent digits and bar.
  // ---------------------------------------------------------------------
  logic [14:0] q_x10;
  logic [14:0] frac_full;
  logic [24:0] q2_prod;
  logic [8:0]  q2;
  logic [11:0] q2_x10;
  logic [11:0] right_full;
  logic [14:0] pt_prod;
  logic [3:0]  pt;
  logic [6:0]  pt_x10;
  logic [6:0]  po_full;

  logic        s2_vld_r;
  logic        s2_neg_r;
  logic        s2_mode_r;
  logic        s2_round_r;
  logic [8:0]  s2_q2_r;
  logic [3:0]  s2_right_r;
  logic        s2_full_r;
  logic [3:0]  s2_pt_r;
  logic [3:0]  s2_po_r;
  logic [4:0]  s2_bar_r;

  always_comb begin
    q_x10      = {s1_q_r, 3'd0} + {2'd0, s1_q_r, 1'b0};
    frac_full  = s1_mv_r - q_x10;
    q2_prod    = {13'd0, s1_q_r} * 25'(bmde_pkg::RECIP10_MID);
    q2         = q2_prod[24:16];
    q2_x10     = {q2[8:0], 3'd0} + {2'd0, q2, 1'b0};
    right_full = s1_q_r - q2_x10;
    pt_prod    = {8'd0, s1_pct_r} * 15'(bmde_pkg::RECIP10_SMALL);
    pt         = pt_prod[14:11];
    pt_x10     = 7'({pt, 3'd0}) + 7'({pt, 1'b0});
    po_full    = s1_pct_r - pt_x10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_neg_r   <= s1_neg_r;
    s2_mode_r  <= s1_mode_r;
    s2_round_r <= (frac_full[3:0] >= 4'd5);
    s2_q2_r    <= q2;
    s2_right_r <= right_full[3:0];
    s2_full_r  <= (s1_pct_r == 7'(bmde_pkg::PCT_FULL));
    s2_pt_r    <= pt;
    s2_po_r    <= po_full[3:0];
    s2_bar_r   <= bmde_pkg::level_bar(s1_pct_r);
  end

  // ---------------------------------------------------------------------
  // Stage 3: middle and left digits.
  // ---------------------------------------------------------------------
  logic [16:0] q3_prod;
  logic [5:0]  q3;
  logic [8:0]  q3_x10;
  logic [8:0]  mid_full;
  logic [5:0]  left_full;

  bmde_pkg::digits_t s3_dig_r;
  logic              s3_vld_r;

  always_comb begin
    q3_prod  = {8'd0, s2_q2_r} * 17'(bmde_pkg::RECIP10_SMALL);
    q3       = q3_prod[16:11];
    q3_x10   = 9'({q3, 3'd0}) + 9'({q3, 1'b0});
    mid_full = s2_q2_r - q3_x10;
    // The quotient stays below forty, so three compares give its last digit.
    if (q3 >= 6'd30) begin
      left_full = q3 - 6'd30;
    end else if (q3 >= 6'd20) begin
      left_full = q3 - 6'd20;
    end else if (q3 >= 6'd10) begin
      left_full = q3 - 6'd10;
    end else begin
      left_full = q3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_dig_r.rejected <= s2_neg_r;
    s3_dig_r.pct_mode <= s2_mode_r;
    s3_dig_r.round_up <= s2_round_r;
    s3_dig_r.left     <= left_full[3:0];
    s3_dig_r.middle   <= mid_full[3:0];
    s3_dig_r.right    <= s2_right_r;
    s3_dig_r.pct_full <= s2_full_r;
    s3_dig_r.pct_tens <= s2_pt_r;
    s3_dig_r.pct_ones <= s2_po_r;
    s3_dig_r.bar      <= s2_bar_r;
  end

  // ---------------------------------------------------------------------
  // Stage 4: rounding, segment encoding and the output register.
  // ---------------------------------------------------------------------
  logic [28:0] word_nxt;
  logic        rej_nxt;
  logic        done_r;
  logic [28:0] word_r;
  logic        rej_r;

  bmde_word_enc u_word_enc (
    .dig          (s3_dig_r),
    .display_word (word_nxt),
    .rejected     (rej_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= s3_vld_r;
    end
    word_r <= word_nxt;
    rej_r  <= rej_nxt;
  end

  assign busy             = 1'b0;
  assign done             = done_r;
  assign out_display_word = word_r;
  assign out_rejected     = rej_r;

endmodule
